>>> rtl/core/hlsf_pkg.sv
// ----------------------------------------------------------------------------
// hlsf_pkg
// Shared widths, types and helpers of the hexahedron shape function block.
// ----------------------------------------------------------------------------
package hlsf_pkg;

	localparam int MAX_DEGREE = 3;
	localparam int NB         = MAX_DEGREE + 1;
	localparam int COORD_W    = 16;
	localparam int SHAPE_W    = 18;
	localparam int NODE_W     = 6;
	localparam int ORD_W      = 2;
	localparam int BASIS_W    = 26;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_ORDER_R = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ORDER_S = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ORDER_T = 2'd2;

	typedef logic signed [BASIS_W-1:0] basis_t;

	typedef enum logic [2:0] {
		SEG_CORNER,
		SEG_EDGE,
		SEG_TEDGE,
		SEG_FACE_S,
		SEG_FACE_R,
		SEG_FACE_T,
		SEG_INTER
	} seg_t;

	function automatic logic [ORD_W-1:0] eff_order(input logic [ORD_W-1:0] reg_val);
		logic [ORD_W-1:0] n;
		n = (reg_val == '0) ? ORD_W'(1) : reg_val;
		if (n > ORD_W'(MAX_DEGREE)) n = ORD_W'(MAX_DEGREE);
		return n;
	endfunction

endpackage

>>> rtl/core/hlsf_axis.sv
// ----------------------------------------------------------------------------
// hlsf_axis
// Five-stage 1D Lagrange basis pipeline for one axis, Q.20 results.
// ----------------------------------------------------------------------------
module hlsf_axis (
	input  logic                                 clk,
	input  logic signed [hlsf_pkg::COORD_W-1:0]  coord,
	input  logic        [hlsf_pkg::ORD_W-1:0]    order,
	output hlsf_pkg::basis_t                     basis [hlsf_pkg::NB]
);
	import hlsf_pkg::*;

	localparam logic [31:0] RECIP3 = 32'h5555_5556;

	logic signed [16:0] cs;
	logic signed [18:0] u_c;
	logic signed [18:0] u_s1;
	logic [ORD_W-1:0]   n_s1, n_s2, n_s3, n_s4;

	logic signed [19:0] f    [NB];
	logic [17:0]        fmag [NB];
	logic               fneg [NB];
	logic [17:0]        fa   [NB];
	logic [17:0]        fb   [NB];
	logic [17:0]        fc   [NB];
	logic               ng   [NB];

	logic [35:0] p2_s2  [NB];
	logic [17:0] f3_s2  [NB];
	logic        neg_s2 [NB];
	logic [53:0] nm_s3  [NB];
	logic        neg_s3 [NB];
	logic [28:0] t_s4   [NB];
	logic        div3_s4[NB];
	logic        neg_s4 [NB];

	logic [54:0] sum_c  [NB];
	logic [28:0] t_c    [NB];
	logic        div3_c [NB];
	logic [60:0] q3_c   [NB];
	logic [28:0] q_c    [NB];

	assign cs  = 17'(coord) + 17'sd16384;
	assign u_c = 19'(cs) * $signed({17'd0, order});

	always_ff @(posedge clk) begin
		u_s1 <= u_c;
		n_s1 <= order;
	end

	always_comb begin
		for (int k = 0; k < NB; k++) begin
			f[k]    = 20'(u_s1) - (20'(k) << 15);
			fneg[k] = f[k][19];
			fmag[k] = f[k][19] ? 18'(-f[k]) : 18'(f[k]);
		end
		for (int j = 0; j < NB; j++) begin
			ng[j] = (n_s1[0] ^ 1'(j)) & (ORD_W'(j) <= n_s1);
			fa[j] = 18'd1;
			fb[j] = 18'd1;
			fc[j] = 18'd1;
			for (int k = 0; k < NB; k++) begin
				if (k != j && ORD_W'(k) <= n_s1) begin
					ng[j] = ng[j] ^ fneg[k];
					if (k == ((j == 0) ? 1 : 0)) fa[j] = fmag[k];
					else if (k == ((j <= 1) ? 2 : 1)) fb[j] = fmag[k];
					else fc[j] = fmag[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		n_s2 <= n_s1;
		n_s3 <= n_s2;
		n_s4 <= n_s3;
		for (int j = 0; j < NB; j++) begin
			p2_s2[j]  <= fa[j] * fb[j];
			f3_s2[j]  <= fc[j];
			neg_s2[j] <= ng[j];
			nm_s3[j]  <= 54'(p2_s2[j] * f3_s2[j]);
			neg_s3[j] <= neg_s2[j];
			t_s4[j]   <= t_c[j];
			div3_s4[j]<= div3_c[j];
			neg_s4[j] <= neg_s3[j];
		end
	end

	always_comb begin
		for (int j = 0; j < NB; j++) begin
			div3_c[j] = (n_s3 == 2'd3) && (j == 0 || j == 3);
			sum_c[j]  = '0;
			t_c[j]    = '0;
			case (n_s3)
				2'd1: t_c[j] = 29'({nm_s3[j], 5'd0});
				2'd2: begin
					if (j == 1) begin
						sum_c[j] = 55'(nm_s3[j]) + 55'(1 << 9);
						t_c[j]   = 29'(sum_c[j] >> 10);
					end else begin
						sum_c[j] = 55'(nm_s3[j]) + 55'(1 << 10);
						t_c[j]   = 29'(sum_c[j] >> 11);
					end
				end
				default: begin
					sum_c[j] = 55'(nm_s3[j]) + (div3_c[j] ? 55'(3 << 25) : 55'(1 << 25));
					t_c[j]   = 29'(sum_c[j] >> 26);
				end
			endcase
		end
	end

	always_comb begin
		for (int j = 0; j < NB; j++) begin
			q3_c[j] = 61'(t_s4[j]) * 61'(RECIP3);
			q_c[j]  = div3_s4[j] ? 29'(q3_c[j] >> 32) : t_s4[j];
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < NB; j++) begin
			basis[j] <= neg_s4[j] ? -BASIS_W'(q_c[j]) : BASIS_W'(q_c[j]);
		end
	end

endmodule

>>> rtl/core/hex_lagrange_shape_function_eval_top.sv
// Throughput: one node per cycle from the node sequencer, except while it steps over an
//   empty node group.
// The next point is taken while the current run is still emitting.
// Reset: arst_n clears all control state; orders return to 1. Results cannot be stalled.
// ----------------------------------------------------------------------------
// hex_lagrange_shape_function_eval_top
// Hexahedron tensor-product Lagrange shape values, one node per cycle except on empty node groups.
// ----------------------------------------------------------------------------
module hex_lagrange_shape_function_eval_top (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     start,
	output logic                                     busy,
	input  logic signed [hlsf_pkg::COORD_W-1:0]      coord_r,
	input  logic signed [hlsf_pkg::COORD_W-1:0]      coord_s,
	input  logic signed [hlsf_pkg::COORD_W-1:0]      coord_t,
	input  logic                                     cfg_valid,
	output logic                                     cfg_ready,
	input  logic        [hlsf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic        [hlsf_pkg::ORD_W-1:0]        cfg_data,
	output logic                                     result_valid,
	output logic signed [hlsf_pkg::SHAPE_W-1:0]      shape_value,
	output logic        [hlsf_pkg::NODE_W-1:0]       node_index,
	output logic                                     last
);
	import hlsf_pkg::*;

	localparam int AXIS_LAT = 5;

	logic [ORD_W-1:0] order_r_q, order_s_q, order_t_q;
	logic [ORD_W-1:0] a, b, c, la, lb, lc;
	logic [6:0]       total;
	logic [NODE_W-1:0] final_idx;

	basis_t br [NB];
	basis_t bs [NB];
	basis_t bt [NB];
	basis_t hold_r_q [NB];
	basis_t hold_s_q [NB];
	basis_t hold_t_q [NB];
	basis_t bank_r_q [NB];
	basis_t bank_s_q [NB];
	basis_t bank_t_q [NB];

	logic [AXIS_LAT-1:0] pv_q;
	logic                hold_v_q;
	logic                accept;

	seg_t             seg_q, seg_n;
	logic [2:0]       grp_q, grp_n, gmax;
	logic [ORD_W-1:0] i_q, j_q, k_q, i_n, j_n, k_n;
	logic [NODE_W-1:0] node_q, node_n;
	logic             run_q, run_n;
	logic             ui, uj, uk, nonempty, emit, run_end, load;
	logic [ORD_W-1:0] x, y, z;
	logic             next_grp;

	basis_t           sr_s1, ss_s1, st_s1, st_s2, st_s3;
	logic [NODE_W-1:0] idx_s1, idx_s2, idx_s3, idx_s4;
	logic             last_s1, last_s2, last_s3, last_s4;
	logic             v_s1, v_s2, v_s3, v_s4;
	logic signed [51:0] p1_s2;
	logic signed [32:0] r1_s3;
	logic signed [58:0] p2_s4;
	logic [51:0]      m1;
	logic [32:0]      q1;
	logic [58:0]      m2;
	logic [33:0]      q2;
	logic signed [34:0] r2;

	assign cfg_ready = 1'b1;
	assign a  = eff_order(order_r_q);
	assign b  = eff_order(order_s_q);
	assign c  = eff_order(order_t_q);
	assign la = a - 2'd1;
	assign lb = b - 2'd1;
	assign lc = c - 2'd1;
	assign total     = 7'({5'd0, a} + 7'd1) * 7'({5'd0, b} + 7'd1) * 7'({5'd0, c} + 7'd1);
	assign final_idx = NODE_W'(total - 7'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_r_q <= ORD_W'(1);
			order_s_q <= ORD_W'(1);
			order_t_q <= ORD_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ORDER_R: order_r_q <= cfg_data;
				CFG_ORDER_S: order_s_q <= cfg_data;
				CFG_ORDER_T: order_t_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign busy   = (|pv_q) || hold_v_q;
	assign accept = start && !busy;

	hlsf_axis u_axis_r (.clk(clk), .coord(coord_r), .order(a), .basis(br));
	hlsf_axis u_axis_s (.clk(clk), .coord(coord_s), .order(b), .basis(bs));
	hlsf_axis u_axis_t (.clk(clk), .coord(coord_t), .order(c), .basis(bt));

	assign run_end = emit && (node_q == final_idx);
	assign load    = hold_v_q && (!run_q || run_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q     <= '0;
			hold_v_q <= 1'b0;
		end else begin
			pv_q <= {pv_q[AXIS_LAT-2:0], accept};
			if (pv_q[AXIS_LAT-1]) hold_v_q <= 1'b1;
			else if (load) hold_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pv_q[AXIS_LAT-1]) begin
			hold_r_q <= br;
			hold_s_q <= bs;
			hold_t_q <= bt;
		end
		if (load) begin
			bank_r_q <= hold_r_q;
			bank_s_q <= hold_s_q;
			bank_t_q <= hold_t_q;
		end
	end

	// node sequencer
	always_comb begin
		ui = 1'b0; uj = 1'b0; uk = 1'b0;
		gmax = 3'd0;
		x = '0; y = '0; z = '0;
		case (seg_q)
			SEG_CORNER: begin
				gmax = 3'd7;
				x = (grp_q[1] ^ grp_q[0]) ? a : '0;
				y = grp_q[1] ? b : '0;
				z = grp_q[2] ? c : '0;
			end
			SEG_EDGE: begin
				gmax = 3'd7;
				z = grp_q[2] ? c : '0;
				if (!grp_q[0]) begin
					ui = 1'b1;
					x  = i_q;
					y  = grp_q[1] ? b : '0;
				end else begin
					uj = 1'b1;
					x  = grp_q[1] ? '0 : a;
					y  = j_q;
				end
			end
			SEG_TEDGE: begin
				gmax = 3'd3;
				uk = 1'b1;
				x = grp_q[0] ? a : '0;
				y = grp_q[1] ? b : '0;
				z = k_q;
			end
			SEG_FACE_S: begin
				gmax = 3'd1;
				uk = 1'b1; uj = 1'b1;
				x = grp_q[0] ? a : '0;
				y = j_q;
				z = k_q;
			end
			SEG_FACE_R: begin
				gmax = 3'd1;
				uk = 1'b1; ui = 1'b1;
				x = i_q;
				y = grp_q[0] ? b : '0;
				z = k_q;
			end
			SEG_FACE_T: begin
				gmax = 3'd1;
				uj = 1'b1; ui = 1'b1;
				x = i_q;
				y = j_q;
				z = grp_q[0] ? c : '0;
			end
			default: begin
				ui = 1'b1; uj = 1'b1; uk = 1'b1;
				x = i_q; y = j_q; z = k_q;
			end
		endcase

		nonempty = !(ui && la == '0) && !(uj && lb == '0) && !(uk && lc == '0);
		emit     = run_q && nonempty;

		seg_n  = seg_q;
		grp_n  = grp_q;
		i_n    = i_q;
		j_n    = j_q;
		k_n    = k_q;
		node_n = node_q;
		run_n  = run_q;
		next_grp = 1'b0;

		if (run_q) begin
			if (!nonempty) begin
				next_grp = 1'b1;
			end else begin
				node_n = node_q + NODE_W'(1);
				if (ui && i_q != la) begin
					i_n = i_q + 2'd1;
				end else begin
					i_n = 2'd1;
					if (uj && j_q != lb) begin
						j_n = j_q + 2'd1;
					end else begin
						j_n = 2'd1;
						if (uk && k_q != lc) begin
							k_n = k_q + 2'd1;
						end else begin
							k_n = 2'd1;
							next_grp = 1'b1;
						end
					end
				end
			end
			if (next_grp) begin
				i_n = 2'd1; j_n = 2'd1; k_n = 2'd1;
				if (grp_q == gmax) begin
					grp_n = '0;
					case (seg_q)
						SEG_CORNER: seg_n = SEG_EDGE;
						SEG_EDGE:   seg_n = SEG_TEDGE;
						SEG_TEDGE:  seg_n = SEG_FACE_S;
						SEG_FACE_S: seg_n = SEG_FACE_R;
						SEG_FACE_R: seg_n = SEG_FACE_T;
						SEG_FACE_T: seg_n = SEG_INTER;
						default:    seg_n = SEG_INTER;
					endcase
				end else begin
					grp_n = grp_q + 3'd1;
				end
			end
			if (run_end) run_n = 1'b0;
		end

		if (load) begin
			run_n  = 1'b1;
			seg_n  = SEG_CORNER;
			grp_n  = '0;
			i_n    = 2'd1;
			j_n    = 2'd1;
			k_n    = 2'd1;
			node_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q  <= SEG_CORNER;
			grp_q  <= '0;
			i_q    <= 2'd1;
			j_q    <= 2'd1;
			k_q    <= 2'd1;
			node_q <= '0;
			run_q  <= 1'b0;
		end else begin
			seg_q  <= seg_n;
			grp_q  <= grp_n;
			i_q    <= i_n;
			j_q    <= j_n;
			k_q    <= k_n;
			node_q <= node_n;
			run_q  <= run_n;
		end
	end

	// product pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			v_s1 <= emit;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			result_valid <= v_s4;
		end
	end

	always_comb begin
		m1 = p1_s2[51] ? 52'(-p1_s2) : 52'(p1_s2);
		q1 = 33'((m1 + 52'(1 << 19)) >> 20);
		m2 = p2_s4[58] ? 59'(-p2_s4) : 59'(p2_s4);
		q2 = 34'((m2 + 59'(1 << 25)) >> 26);
		r2 = p2_s4[58] ? -35'(q2) : 35'(q2);
	end

	always_ff @(posedge clk) begin
		sr_s1   <= bank_r_q[x];
		ss_s1   <= bank_s_q[y];
		st_s1   <= bank_t_q[z];
		idx_s1  <= node_q;
		last_s1 <= run_end;

		p1_s2   <= 52'(sr_s1) * 52'(ss_s1);
		st_s2   <= st_s1;
		idx_s2  <= idx_s1;
		last_s2 <= last_s1;

		r1_s3   <= p1_s2[51] ? -33'(q1) : 33'(q1);
		st_s3   <= st_s2;
		idx_s3  <= idx_s2;
		last_s3 <= last_s2;

		p2_s4   <= 59'(r1_s3) * 59'(st_s3);
		idx_s4  <= idx_s3;
		last_s4 <= last_s3;

		if (r2 > 35'sd131071) shape_value <= 18'sd131071;
		else if (r2 < -35'sd131072) shape_value <= -18'sd131072;
		else shape_value <= SHAPE_W'(r2);
		node_index <= idx_s4;
		last       <= last_s4;
	end

endmodule
